// ----- hdl/pft_pkg.sv -----
// shared types, constants and widths for the peak frequency tracker
`default_nettype none

package pft_pkg;

  // history depth and frequency format
  localparam int WINDOW    = 5;
  localparam int FRAC_BITS = 12;
  localparam int FREQ_W    = 15;
  localparam int RATE_W    = 21;
  localparam int HR_SCALE  = 60;

  // configuration register widths and reset values
  localparam int THR_W  = 15;
  localparam int MISS_W = 8;
  localparam int CNT_W  = 4;
  localparam int CSG_W  = 8;
  localparam logic [THR_W-1:0]  THR_RESET     = THR_W'((2 ** FRAC_BITS) / 5);
  localparam logic [MISS_W-1:0] MISS_RESET    = MISS_W'(3);
  localparam logic [CNT_W-1:0]  RESTART_RESET = CNT_W'(2);

  // register bus
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MISS      = 2'd1;
  localparam logic [1:0] REG_RESTART   = 2'd2;

  // datapath widths
  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = FREQ_W + $clog2(WINDOW);

  // divide by WINDOW-2 as multiply by reciprocal, exact for x < 2**SUM_W
  localparam int DIVISOR  = WINDOW - 2;
  localparam int DIV_K    = SUM_W + 3;
  localparam int DIV_MW   = DIV_K + 1;
  localparam int DIV_MULT = ((2 ** DIV_K) + DIVISOR - 1) / DIVISOR;
  localparam int PROD_W   = SUM_W + DIV_MW;

  typedef enum logic [1:0] {
    COND_NORMAL = 2'd0,
    COND_GOOD   = 2'd1,
    COND_BAD    = 2'd2
  } cond_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_TEST,
    S_SUM2,
    S_DIV,
    S_LOAD,
    S_SORT,
    S_MEDLO,
    S_MEDHI,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [THR_W-1:0]  thr;
    logic [MISS_W-1:0] miss;
    logic [CNT_W-1:0]  restart;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/peak_frequency_tracker.sv -----
// peak frequency tracker: history, outlier repair, median and heart rate
//
//   channel  direction  signals
//   input    in         in_valid_i, in_ready_o, peak_frequency_i
//   output   out        out_valid_o, out_ready_i, median_frequency_o, heart_rate_o, condition_o
//   config   in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// while filling, an item goes straight to the sort; otherwise the window is summed first,
// and a replaced item is summed again and divided; the sort through the single comparator
// sets most of the time taken, plus the window sums through the same adder
// in_ready_o is high only while the sequencer is idle
// a finished result waits in the output register; the next item is taken meanwhile
// reset clears the history, fill count and miss counter at once
`default_nettype none

module peak_frequency_tracker
  import pft_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FREQ_W-1:0] peak_frequency_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FREQ_W-1:0] median_frequency_o,
  output logic [RATE_W-1:0] heart_rate_o,
  output logic [1:0]        condition_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  state_e state_q, state_d;

  logic [FREQ_W-1:0] hist_q [WINDOW];
  logic [FREQ_W-1:0] sort_q [WINDOW];
  logic [CNT_W-1:0]  fill_q;
  logic [CSG_W-1:0]  csg_q;
  logic [FREQ_W-1:0] freq_q;
  logic [SUM_W-1:0]  acc_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  pass_q;
  logic [IDX_W-1:0]  lo_q, hi_q;
  logic              empty_q;
  cond_e             cond_q;

  logic              out_valid_q;
  logic [FREQ_W-1:0] med_q;
  logic [RATE_W-1:0] hr_q;
  cond_e             out_cond_q;

  logic [SUM_W-1:0]  alu_a, alu_b, alu_sum;
  logic              alu_gt;
  logic              in_ready;
  logic              in_xfer;
  logic              filling;
  logic              accept_ok;
  logic              miss_over;
  logic              hist_shift;
  logic [FREQ_W-1:0] hist_in;
  logic [SUM_W-1:0]  scaled;
  logic [SUM_W-1:0]  diff_abs;
  logic [SUM_W-1:0]  thr_scaled;
  logic [PROD_W-1:0] div_prod;
  logic [FREQ_W-1:0] div_q;
  logic [CNT_W-1:0]  n_cnt;
  logic [CNT_W-1:0]  n_off;
  logic [CNT_W-1:0]  lo_cnt, hi_cnt;
  logic              out_free;
  logic [FREQ_W-1:0] med_val;

  pft_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pft_alu u_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .sum_o    (alu_sum),
    .a_gt_b_o (alu_gt)
  );

  assign in_xfer   = in_valid_i & in_ready;
  assign filling   = (fill_q <= CNT_W'(WINDOW));
  assign out_free  = ~out_valid_q | out_ready_i;
  assign miss_over = (csg_q > cfg.miss);

  // acceptance test: |sum - WINDOW*value| < WINDOW*threshold
  assign scaled     = SUM_W'(freq_q) * SUM_W'(WINDOW);
  assign thr_scaled = SUM_W'(cfg.thr) * SUM_W'(WINDOW);
  assign diff_abs   = (acc_q > scaled) ? (acc_q - scaled) : (scaled - acc_q);
  assign accept_ok  = (diff_abs < thr_scaled);

  // replacement mean by reciprocal multiply
  assign div_prod = PROD_W'(acc_q) * PROD_W'(DIV_MULT);
  assign div_q    = div_prod[DIV_K +: FREQ_W];

  // median span and the two middle positions of the sorted line
  assign n_cnt  = (fill_q > CNT_W'(WINDOW)) ? CNT_W'(WINDOW) : fill_q;
  assign n_off  = CNT_W'(WINDOW) - n_cnt;
  assign lo_cnt = n_off + ((n_cnt - CNT_W'(1)) >> 1);
  assign hi_cnt = n_off + (n_cnt >> 1);

  // sequencer: next state and shared unit operands
  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    alu_a    = acc_q;
    alu_b    = SUM_W'(hist_q[idx_q]);
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = filling ? S_LOAD : S_SUM;
        end
      end
      S_SUM: begin
        if (idx_q == IDX_W'(WINDOW - 1)) begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        state_d = accept_ok ? S_LOAD : S_SUM2;
      end
      S_SUM2: begin
        if (idx_q == IDX_W'(WINDOW - 2)) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        state_d = S_LOAD;
      end
      S_LOAD: begin
        state_d = S_SORT;
      end
      S_SORT: begin
        alu_a = SUM_W'(sort_q[0]);
        alu_b = SUM_W'(sort_q[1]);
        if (idx_q == IDX_W'(WINDOW - 1) && pass_q == IDX_W'(WINDOW - 2)) begin
          state_d = S_MEDLO;
        end
      end
      S_MEDLO: begin
        state_d = S_MEDHI;
      end
      S_MEDHI: begin
        alu_b   = SUM_W'(sort_q[hi_q]);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = in_ready;

  // history shift source
  always_comb begin
    hist_shift = 1'b0;
    hist_in    = div_q;
    case (state_q)
      S_IDLE: begin
        hist_shift = in_xfer & filling;
        hist_in    = peak_frequency_i;
      end
      S_TEST: begin
        hist_shift = accept_ok;
        hist_in    = freq_q;
      end
      S_DIV: begin
        hist_shift = 1'b1;
      end
      default: begin
        hist_shift = 1'b0;
      end
    endcase
  end

  // history, fill count and miss counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        hist_q[i] <= '0;
      end
      fill_q <= '0;
      csg_q  <= '0;
    end else begin
      if (hist_shift) begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          hist_q[i] <= hist_q[i+1];
        end
        hist_q[WINDOW-1] <= hist_in;
      end
      if (in_xfer) begin
        csg_q <= (csg_q != '1) ? csg_q + CSG_W'(1) : csg_q;
        if (filling) begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
      if (state_q == S_TEST && accept_ok) begin
        csg_q <= '0;
      end
      if (state_q == S_DIV && miss_over) begin
        fill_q <= cfg.restart;
      end
    end
  end

  // working registers of the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          freq_q <= peak_frequency_i;
          cond_q <= COND_NORMAL;
          acc_q  <= '0;
          idx_q  <= '0;
        end
      end
      S_SUM: begin
        acc_q <= alu_sum;
        idx_q <= idx_q + IDX_W'(1);
      end
      S_TEST: begin
        acc_q <= '0;
        idx_q <= IDX_W'(1);
        if (accept_ok) begin
          cond_q <= COND_GOOD;
        end
      end
      S_SUM2: begin
        acc_q <= alu_sum;
        idx_q <= idx_q + IDX_W'(1);
      end
      S_DIV: begin
        cond_q <= miss_over ? COND_BAD : COND_NORMAL;
      end
      S_LOAD: begin
        // entries older than the span read as zero and sort to the front
        for (int i = 0; i < WINDOW; i++) begin
          sort_q[i] <= (CNT_W'(i) >= n_off) ? hist_q[i] : '0;
        end
        lo_q    <= lo_cnt[IDX_W-1:0];
        hi_q    <= hi_cnt[IDX_W-1:0];
        empty_q <= (n_cnt == '0);
        idx_q   <= '0;
        pass_q  <= '0;
      end
      S_SORT: begin
        // bubble pass: carry the larger at the head, drop the smaller at the tail
        for (int i = 1; i < WINDOW - 1; i++) begin
          sort_q[i] <= sort_q[i+1];
        end
        if (idx_q != IDX_W'(WINDOW - 1)) begin
          sort_q[0]        <= alu_gt ? sort_q[0] : sort_q[1];
          sort_q[WINDOW-1] <= alu_gt ? sort_q[1] : sort_q[0];
          idx_q            <= idx_q + IDX_W'(1);
        end else begin
          sort_q[0]        <= sort_q[1];
          sort_q[WINDOW-1] <= sort_q[0];
          idx_q            <= '0;
          pass_q           <= pass_q + IDX_W'(1);
        end
      end
      S_MEDLO: begin
        acc_q <= SUM_W'(sort_q[lo_q]);
      end
      S_MEDHI: begin
        acc_q <= alu_sum;
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  // result register
  assign med_val = empty_q ? '0 : acc_q[FREQ_W:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      med_q      <= med_val;
      hr_q       <= RATE_W'(med_val) * RATE_W'(HR_SCALE);
      out_cond_q <= cond_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign median_frequency_o = med_q;
  assign heart_rate_o       = hr_q;
  assign condition_o        = out_cond_q;

`ifndef NO_ASSERTIONS
  // an accepted item keeps the sequencer busy for the next cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input taken again right after a transfer");

  // heart rate always tracks the delivered median
  a_rate_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heart_rate_o == RATE_W'(median_frequency_o) * RATE_W'(HR_SCALE))
    else $error("heart rate out of step with median");

  // a good result always leaves the miss counter cleared
  a_good_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && cond_q == COND_GOOD) |-> csg_q == '0)
    else $error("good result with miss counter set");

  // the output never goes idle while a result is waiting
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_free) |=> out_valid_o && state_q == S_DONE)
    else $error("pending result lost");
`endif

endmodule

`default_nettype wire

// ----- hdl/pft_alu.sv -----
// shared adder and magnitude comparator used by the sum, sort and median steps
`default_nettype none

module pft_alu
  import pft_pkg::*;
(
  input  logic [SUM_W-1:0] a_i,
  input  logic [SUM_W-1:0] b_i,
  output logic [SUM_W-1:0] sum_o,
  output logic             a_gt_b_o
);

  // accumulate and compare share the operands
  assign sum_o    = a_i + b_i;
  assign a_gt_b_o = (a_i > b_i);

endmodule

`default_nettype wire

// ----- hdl/pft_cfg.sv -----
// register bank behind the configuration bus
`default_nettype none

module pft_cfg
  import pft_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // register writes, unknown addresses dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thr     <= THR_RESET;
      cfg_q.miss    <= MISS_RESET;
      cfg_q.restart <= RESTART_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_THRESHOLD: cfg_q.thr     <= pwdata[THR_W-1:0];
        REG_MISS:      cfg_q.miss    <= pwdata[MISS_W-1:0];
        REG_RESTART:   cfg_q.restart <= pwdata[CNT_W-1:0];
        default:       cfg_q         <= cfg_q;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = APB_DW'(cfg_q.thr);
      REG_MISS:      prdata = APB_DW'(cfg_q.miss);
      REG_RESTART:   prdata = APB_DW'(cfg_q.restart);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire
